@@ hdl/shbi_pkg.sv @@
// String hash bucket index: shared package.
// Holds field widths, hash kind codes, register indexes, control structs and
// the per-byte hash functions. No dependencies.
`timescale 1ns / 1ps

package shbi_pkg;

	localparam int BYTE_W   = 8;
	localparam int HASH_W   = 64;
	localparam int CNT_W    = 32;
	localparam int KIND_W   = 4;
	localparam int BCNT_W   = 17;
	localparam int BIDX_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam int DIV_STEPS = HASH_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] CFG_HASH_KIND    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 1'b1;

	localparam logic [KIND_W-1:0] KIND_ZERO   = 4'd0;
	localparam logic [KIND_W-1:0] KIND_FIRST  = 4'd1;
	localparam logic [KIND_W-1:0] KIND_LEN    = 4'd2;
	localparam logic [KIND_W-1:0] KIND_SUM    = 4'd3;
	localparam logic [KIND_W-1:0] KIND_ROL    = 4'd4;
	localparam logic [KIND_W-1:0] KIND_ROR    = 4'd5;
	localparam logic [KIND_W-1:0] KIND_DJB2   = 4'd6;
	localparam logic [KIND_W-1:0] KIND_CRC32  = 4'd7;
	localparam logic [KIND_W-1:0] KIND_CRC32C = 4'd8;

	localparam logic [KIND_W-1:0] HASH_KIND_RST    = KIND_CRC32;
	localparam logic [BCNT_W-1:0] BUCKET_COUNT_RST = 17'd4096;

	localparam logic [HASH_W-1:0] DJB2_START  = 64'd5381;
	localparam logic [HASH_W-1:0] CRC_START   = 64'h0000_0000_FFFF_FFFF;
	localparam logic [HASH_W-1:0] LOW32       = 64'h0000_0000_FFFF_FFFF;
	localparam logic [HASH_W-1:0] CRC32_POLY  = 64'h0000_0000_EDB8_8320;
	localparam logic [HASH_W-1:0] CRC32C_POLY = 64'h0000_0000_82F6_3B78;
	localparam logic [CNT_W-1:0]  CNT_MAX     = '1;

	// controller to datapath
	typedef struct packed {
		logic item_en;   // an item is accepted this cycle
		logic div_load;  // accepted item closes a word: start the remainder
		logic div_step;  // one remainder iteration
		logic out_load;  // move the finished result into the output register
	} shbi_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic finish_item;  // item on the input closes a word
	} shbi_stat_t;

	function automatic logic [HASH_W-1:0] sext8(input logic [BYTE_W-1:0] b);
		return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
	endfunction

	function automatic logic [HASH_W-1:0] start_value(input logic [KIND_W-1:0] kind);
		logic [HASH_W-1:0] v;
		unique case (kind)
			KIND_DJB2:               v = DJB2_START;
			KIND_CRC32, KIND_CRC32C: v = CRC_START;
			default:                 v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [HASH_W-1:0] hash_update(input logic [KIND_W-1:0] kind,
			input logic [HASH_W-1:0] acc, input logic [BYTE_W-1:0] b, input logic first);
		logic [HASH_W-1:0] s;
		logic [HASH_W-1:0] a;
		s = sext8(b);
		a = acc;
		unique case (kind)
			KIND_FIRST: a = first ? s : acc;
			KIND_SUM:   a = acc + s;
			KIND_ROL:   a = {acc[HASH_W-2:0], acc[HASH_W-1]} ^ s;
			KIND_ROR:   a = {acc[0], acc[HASH_W-1:1]} ^ s;
			KIND_DJB2:  a = (acc << 5) + acc + s;
			KIND_CRC32: begin
				a = acc ^ s;
				for (int i = 0; i < BYTE_W; i++) begin
					a = a[0] ? ((a >> 1) ^ CRC32_POLY) : (a >> 1);
				end
			end
			KIND_CRC32C: begin
				a = (acc ^ {{(HASH_W-BYTE_W){1'b0}}, b}) & LOW32;
				for (int i = 0; i < BYTE_W; i++) begin
					a = a[0] ? ((a >> 1) ^ CRC32C_POLY) : (a >> 1);
				end
			end
			default: a = acc;
		endcase
		return a;
	endfunction

	function automatic logic [HASH_W-1:0] hash_finish(input logic [KIND_W-1:0] kind,
			input logic [HASH_W-1:0] acc, input logic [CNT_W-1:0] count);
		logic [HASH_W-1:0] h;
		unique case (kind)
			KIND_FIRST, KIND_SUM, KIND_ROL, KIND_ROR, KIND_DJB2: h = acc;
			KIND_LEN:    h = HASH_W'(count);
			KIND_CRC32:  h = acc ^ LOW32;
			KIND_CRC32C: h = (acc & LOW32) ^ LOW32;
			default:     h = '0;
		endcase
		return h;
	endfunction

endpackage

@@ hdl/shbi_ctrl.sv @@
// String hash bucket index: controller.
// Handshake, remainder sequencing and output-register valid. Uses shbi_pkg.
`timescale 1ns / 1ps

module shbi_ctrl
	import shbi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	output logic       result_valid,
	input  logic       result_ready,
	input  shbi_stat_t stat,
	output shbi_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic                 accept;

	// bytes inside a word pass while the remainder unit is busy
	assign item_ready   = (state_q == ST_IDLE) || !stat.finish_item;
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;

	always_comb begin
		cmd.item_en  = accept;
		cmd.div_load = accept && stat.finish_item;
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_DONE) && (!out_valid_q || result_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.div_load) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hdl/shbi_datapath.sv @@
// String hash bucket index: datapath.
// Config registers, running hash and length, radix-2 remainder, output register.
// Uses shbi_pkg.
`timescale 1ns / 1ps

module shbi_datapath
	import shbi_pkg::*;
#(
	parameter int MAX_BUCKETS = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BCNT_W-1:0]    cfg_data,
	input  logic [BYTE_W-1:0]    char_byte,
	input  logic                 last,
	input  logic                 empty_word,
	input  shbi_cmd_t            cmd,
	output shbi_stat_t           stat,
	output logic [HASH_W-1:0]    hash_value,
	output logic [BIDX_W-1:0]    bucket_index
);

	localparam int CW = $clog2(MAX_BUCKETS + 1);
	localparam int EW = (CW > BCNT_W) ? CW : BCNT_W;
	localparam int RW = (CW > BIDX_W) ? CW : BIDX_W;

	logic [KIND_W-1:0] hash_kind_q;
	logic [BCNT_W-1:0] bucket_count_q;

	logic [HASH_W-1:0] acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              in_word_q;

	logic [HASH_W-1:0] hash_q;
	logic [HASH_W-1:0] dvd_q;
	logic [CW-1:0]     rem_q;

	logic [HASH_W-1:0] hash_value_q;
	logic [BIDX_W-1:0] bucket_index_q;

	logic              first;
	logic [HASH_W-1:0] acc_base;
	logic [HASH_W-1:0] acc_upd;
	logic [CNT_W-1:0]  cnt_base;
	logic [CNT_W-1:0]  cnt_upd;
	logic [HASH_W-1:0] hash_fin;

	logic [EW-1:0]     bc_ext;
	logic [EW-1:0]     div_eff;
	logic [CW-1:0]     divisor;
	logic [CW:0]       trial;
	logic [CW-1:0]     rem_next;
	logic [RW-1:0]     rem_ext;

	assign stat.finish_item = last || empty_word;

	always_comb begin
		first    = !in_word_q;
		acc_base = first ? start_value(hash_kind_q) : acc_q;
		acc_upd  = hash_update(hash_kind_q, acc_base, char_byte, first);
		cnt_base = first ? '0 : cnt_q;
		cnt_upd  = (cnt_base == CNT_MAX) ? cnt_base : cnt_base + 1'b1;
		if (empty_word) begin
			hash_fin = hash_finish(hash_kind_q, start_value(hash_kind_q), '0);
		end else begin
			hash_fin = hash_finish(hash_kind_q, acc_upd, cnt_upd);
		end
	end

	// zero buckets acts as one, large counts clamp to the table size
	always_comb begin
		bc_ext = EW'(bucket_count_q);
		if (bc_ext == '0) begin
			div_eff = EW'(1);
		end else if (bc_ext > EW'(MAX_BUCKETS)) begin
			div_eff = EW'(MAX_BUCKETS);
		end else begin
			div_eff = bc_ext;
		end
		divisor = div_eff[CW-1:0];
		trial   = {rem_q, dvd_q[HASH_W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = CW'(trial - {1'b0, divisor});
		end else begin
			rem_next = trial[CW-1:0];
		end
		rem_ext = RW'(rem_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_kind_q    <= HASH_KIND_RST;
			bucket_count_q <= BUCKET_COUNT_RST;
			in_word_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HASH_KIND:    hash_kind_q    <= cfg_data[KIND_W-1:0];
					CFG_BUCKET_COUNT: bucket_count_q <= cfg_data;
					default:          ;
				endcase
			end
			if (cmd.item_en) begin
				in_word_q <= !stat.finish_item;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_en) begin
			acc_q <= stat.finish_item ? '0 : acc_upd;
			cnt_q <= stat.finish_item ? '0 : cnt_upd;
		end
		if (cmd.div_load) begin
			hash_q <= hash_fin;
			dvd_q  <= hash_fin;
			rem_q  <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[HASH_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.out_load) begin
			hash_value_q   <= hash_q;
			bucket_index_q <= rem_ext[BIDX_W-1:0];
		end
	end

	assign hash_value   = hash_value_q;
	assign bucket_index = bucket_index_q;

endmodule

@@ hdl/string_hash_bucket_index_core.sv @@
// String hash bucket index core: top level, uses shbi_pkg, shbi_ctrl, shbi_datapath.
// Throughput: one byte per cycle for bytes inside a word; a word-closing item is not
// taken while the one-bit-per-cycle remainder loop over the 64-bit hash or its result is busy.
// Result path: a taken word-closing item loads the remainder loop, then the output register.
// Reset: arst_n clears control state and loads hash_kind 7, bucket_count 4096.
`timescale 1ns / 1ps

module string_hash_bucket_index_core
	import shbi_pkg::*;
#(
	parameter int MAX_BUCKETS = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BCNT_W-1:0]    cfg_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [BYTE_W-1:0]    char_byte,
	input  logic                 last,
	input  logic                 empty_word,
	output logic                 result_valid,
	input  logic                 result_ready,
	output logic [HASH_W-1:0]    hash_value,
	output logic [BIDX_W-1:0]    bucket_index
);

	shbi_cmd_t  cmd;
	shbi_stat_t stat;

	shbi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	shbi_datapath #(
		.MAX_BUCKETS (MAX_BUCKETS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.char_byte    (char_byte),
		.last         (last),
		.empty_word   (empty_word),
		.cmd          (cmd),
		.stat         (stat),
		.hash_value   (hash_value),
		.bucket_index (bucket_index)
	);

`ifndef ASSERT_OFF
	// a new remainder never starts on top of one just started
	a_no_double_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_load |=> !(item_valid && item_ready && stat.finish_item))
		else $error("word-closing item taken while remainder busy");

	// never overwrite a result that is still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result_valid || result_ready))
		else $error("output register overwritten");

	// result valid only rises after an output load
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.out_load))
		else $error("result valid without output load");
`endif

endmodule

@@ test/string_hash_bucket_index_core_test.sv @@
// Self-checking testbench for string_hash_bucket_index_core.
// Streams random words under every hash kind and a spread of bucket counts; a scoreboard class
// predicts hash and bucket per word. Depends on shbi_pkg and the core RTL only.
`timescale 1ns / 1ps

module string_hash_bucket_index_core_test;
	import shbi_pkg::*;

	localparam int BUCKET_CAP   = 65536;
	localparam int ITEM_TARGET  = 1450;
	localparam int DRAIN_CYCLES = 80;
	localparam int QUIET_LIMIT  = 5000;
	localparam logic [KIND_W-1:0] KIND_SPARE_LOW = 4'd9;
	localparam logic [KIND_W-1:0] KIND_SPARE_TOP = 4'd15;

	typedef struct {
		logic [HASH_W-1:0] hash;
		logic [BIDX_W-1:0] bucket;
	} word_digest_t;

	class word_hash_book;
		logic [KIND_W-1:0] kind = HASH_KIND_RST;
		logic [BCNT_W-1:0] buckets = BUCKET_COUNT_RST;
		logic [HASH_W-1:0] running = '0;
		logic [CNT_W-1:0]  seen = '0;
		logic              open_word = 1'b0;
		word_digest_t      pending_digests[$];
		int unsigned       items = 0;
		int unsigned       words = 0;
		int unsigned       writes = 0;
		int unsigned       mismatches = 0;

		function logic [HASH_W-1:0] seed_for(logic [KIND_W-1:0] k);
			if (k == KIND_DJB2)
				return DJB2_START;
			if (k == KIND_CRC32 || k == KIND_CRC32C)
				return CRC_START;
			return '0;
		endfunction

		function logic [HASH_W-1:0] absorb(logic [KIND_W-1:0] k, logic [HASH_W-1:0] h,
				logic [BYTE_W-1:0] b, logic fresh);
			logic [HASH_W-1:0] wide;
			wide = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
			case (k)
				KIND_FIRST: if (fresh) h = wide;
				KIND_SUM:   h = h + wide;
				KIND_ROL:   h = {h[HASH_W-2:0], h[HASH_W-1]} ^ wide;
				KIND_ROR:   h = {h[0], h[HASH_W-1:1]} ^ wide;
				KIND_DJB2:  h = h * 33 + wide;
				KIND_CRC32: begin
					h = h ^ wide;
					repeat (BYTE_W) h = (h >> 1) ^ (h[0] ? CRC32_POLY : '0);
				end
				KIND_CRC32C: begin
					h = (h ^ HASH_W'(b)) & LOW32;
					repeat (BYTE_W) h = (h >> 1) ^ (h[0] ? CRC32C_POLY : '0);
				end
				default: ;
			endcase
			return h;
		endfunction

		function logic [HASH_W-1:0] close(logic [KIND_W-1:0] k, logic [HASH_W-1:0] h,
				logic [CNT_W-1:0] n);
			case (k)
				KIND_FIRST, KIND_SUM, KIND_ROL, KIND_ROR, KIND_DJB2: return h;
				KIND_LEN:    return HASH_W'(n);
				KIND_CRC32:  return h ^ LOW32;
				KIND_CRC32C: return (h & LOW32) ^ LOW32;
				default:     return '0;
			endcase
		endfunction

		function void configure(logic [CFG_IDX_W-1:0] idx, logic [BCNT_W-1:0] val);
			writes++;
			if (idx == CFG_HASH_KIND)
				kind = val[KIND_W-1:0];
			else
				buckets = val;
		endfunction

		function void take_item(logic [BYTE_W-1:0] b, logic l, logic e);
			word_digest_t d;
			logic [HASH_W-1:0] n;
			logic fresh;
			items++;
			if (e) begin
				d.hash = close(kind, seed_for(kind), '0);
			end else begin
				fresh = !open_word;
				if (fresh) begin
					running = seed_for(kind);
					seen = '0;
					open_word = 1'b1;
				end
				running = absorb(kind, running, b, fresh);
				if (seen != CNT_MAX)
					seen++;
				if (!l)
					return;
				d.hash = close(kind, running, seen);
			end
			running = '0;
			seen = '0;
			open_word = 1'b0;
			n = (buckets == '0) ? HASH_W'(1) :
				(buckets > BCNT_W'(BUCKET_CAP)) ? HASH_W'(BUCKET_CAP) : HASH_W'(buckets);
			d.bucket = BIDX_W'(d.hash % n);
			pending_digests.push_back(d);
		endfunction

		task report(string what, logic [HASH_W-1:0] got, logic [HASH_W-1:0] want);
			mismatches++;
			$display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
		endtask

		task match_result(logic [HASH_W-1:0] h, logic [BIDX_W-1:0] idx);
			word_digest_t d;
			words++;
			if (pending_digests.size() == 0) begin
				report("unexpected result", h, '0);
				return;
			end
			d = pending_digests.pop_front();
			if (h !== d.hash)
				report("hash_value", h, d.hash);
			if (idx !== d.bucket)
				report("bucket_index", HASH_W'(idx), HASH_W'(d.bucket));
		endtask

		function int waiting();
			return pending_digests.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BCNT_W-1:0]    cfg_data;
	logic                 item_valid;
	logic                 item_ready;
	logic [BYTE_W-1:0]    char_byte;
	logic                 last;
	logic                 empty_word;
	logic                 result_valid;
	logic                 result_ready;
	logic [HASH_W-1:0]    hash_value;
	logic [BIDX_W-1:0]    bucket_index;

	word_hash_book book = new();
	bit            calm = 1'b0;
	int unsigned   items_sent = 0;
	int unsigned   quiet = 0;
	int unsigned   bucket_extremes[9] = '{0, 1, 2, 65535, 65536, 65537, 131071, 4096, 3};

	string_hash_bucket_index_core #(.MAX_BUCKETS(BUCKET_CAP)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready),
		.char_byte(char_byte), .last(last), .empty_word(empty_word),
		.result_valid(result_valid), .result_ready(result_ready),
		.hash_value(hash_value), .bucket_index(bucket_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one; none at all in calm phases
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			default: return BYTE_W'($urandom());
		endcase
	endfunction

	function automatic logic [BCNT_W-1:0] pick_buckets();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return BCNT_W'(1);
			2: return BCNT_W'(BUCKET_CAP);
			3: return BCNT_W'($urandom_range(BUCKET_CAP + 1, 131071));
			4: return BCNT_W'($urandom_range(2, 16));
			5: return BCNT_W'(1) << $urandom_range(0, 16);
			default: return BCNT_W'($urandom_range(1, BUCKET_CAP - 1));
		endcase
	endfunction

	function automatic logic [BCNT_W-1:0] pick_kind();
		if ($urandom_range(0, 9) == 0)
			return BCNT_W'($urandom_range(KIND_SPARE_LOW, KIND_SPARE_TOP));
		return BCNT_W'($urandom_range(KIND_ZERO, KIND_CRC32C));
	endfunction

	task automatic send_item(input logic [BYTE_W-1:0] b, input logic l, input logic e);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		char_byte <= b;
		last <= l;
		empty_word <= e;
		do @(posedge clk); while (!item_ready);
		book.take_item(b, l, e);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BCNT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		book.configure(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// hold the sender until every word is out and the core has gone quiet
	task automatic settle();
		item_valid <= 1'b0;
		while (book.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_bytes(input int unsigned n, input logic close_word);
		for (int unsigned i = 0; i < n; i++)
			send_item(pick_byte(), close_word && (i == n - 1), 1'b0);
	endtask

	initial begin : sink
		int unsigned stall;
		stall = 0;
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				book.match_result(hash_value, bucket_index);
			if (stall == 0 && $urandom_range(0, 3) == 0)
				stall = pick_gap();
			if (stall > 0) begin
				stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned roll;
		int unsigned words;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		item_valid <= 1'b0;
		char_byte <= '0;
		last <= 1'b0;
		empty_word <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty word, then a lone zero byte as a full word
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		for (int k = KIND_ZERO; k <= KIND_CRC32C; k++) begin
			settle();
			write_reg(CFG_HASH_KIND, BCNT_W'(k));
			write_reg(CFG_BUCKET_COUNT, BCNT_W'(bucket_extremes[k]));
			send_item(8'h80, 1'b0, 1'b0);
			send_item(8'h7F, 1'b1, 1'b0);
		end
		// switch kind with a word open
		send_item(8'hC1, 1'b0, 1'b0);
		settle();
		write_reg(CFG_HASH_KIND, BCNT_W'(KIND_DJB2));
		send_item(8'hFF, 1'b1, 1'b0);
		send_item(8'h00, 1'b1, 1'b1);
		// empty word drops the open one
		send_item(8'h12, 1'b0, 1'b0);
		send_item(8'hFF, 1'b0, 1'b1);
		settle();
		write_reg(CFG_HASH_KIND, BCNT_W'(KIND_SPARE_TOP));
		send_item(8'h55, 1'b1, 1'b0);

		while (items_sent < ITEM_TARGET) begin
			settle();
			calm = ($urandom_range(0, 3) == 0);
			write_reg(CFG_HASH_KIND, pick_kind());
			if ($urandom_range(0, 1) == 0)
				write_reg(CFG_BUCKET_COUNT, pick_buckets());
			words = $urandom_range(4, 20);
			repeat (words) begin
				roll = $urandom_range(0, 99);
				if (roll < 8) begin
					send_item(BYTE_W'($urandom()), 1'($urandom()), 1'b1);
				end else if (roll < 12) begin
					send_bytes($urandom_range(1, 5), 1'b0);
					send_item(BYTE_W'($urandom()), 1'($urandom()), 1'b1);
				end else if (roll < 15) begin
					send_bytes($urandom_range(1, 3), 1'b0);
					settle();
					write_reg(CFG_HASH_KIND, pick_kind());
					send_bytes($urandom_range(1, 3), 1'b1);
				end else if (roll < 22) begin
					send_bytes($urandom_range(9, 40), 1'b1);
				end else begin
					send_bytes($urandom_range(1, 6), 1'b1);
				end
			end
		end

		item_valid <= 1'b0;
		while (book.waiting() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d items and %0d finished words over %0d register writes,",
			book.items, book.words, book.writes);
		$display("all hash kinds, spare kinds and bucket counts from 0 to 131071; %0d mismatches",
			book.mismatches);
		if (book.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/shbi_pkg.sv
hdl/shbi_ctrl.sv
hdl/shbi_datapath.sv
hdl/string_hash_bucket_index_core.sv
test/string_hash_bucket_index_core_test.sv
